>>> rtl/core/dss_pkg.sv
// ---------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the delimiter string splitter.
// ---------------------------------------------------------------------------
package dss_pkg;

    // one row byte request as it enters the splitter
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       row_last;
    } item_t;

    // one result of the splitter
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       piece_end;
        logic       row_done;
    } result_t;

    // register index, taken from address bit 3
    typedef enum logic {
        REG_LENGTH = 1'b0,
        REG_BYTES  = 1'b1
    } reg_idx_t;

    localparam logic [3:0]  LEN_RESET   = 4'd1;
    localparam logic [63:0] DELIM_RESET = 64'd44;

endpackage

>>> rtl/core/dss_match.sv
// ---------------------------------------------------------------------------
// dss_match
// Match window and single-pass split logic: takes one request, compares all
// window suffixes against the delimiter in parallel and builds the result list.
// ---------------------------------------------------------------------------
module dss_match
    import dss_pkg::*;
#(
    parameter int MAX_DELIM   = 8,
    parameter int BATCH_DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_clear,
    input  logic                                 fire,
    input  item_t                                item,
    input  logic [$clog2(MAX_DELIM + 1)-1:0]     eff_len,
    input  logic [63:0]                          delim,
    output result_t [BATCH_DEPTH-1:0]            res,
    output logic [$clog2(BATCH_DEPTH + 1)-1:0]   res_count
);

    localparam int CNT_W  = $clog2(MAX_DELIM + 1);
    localparam int BCNT_W = $clog2(BATCH_DEPTH + 1);

    logic [MAX_DELIM-1:0][7:0] window_reg;
    logic [MAX_DELIM-1:0][7:0] window_next;
    logic [CNT_W-1:0]          held_reg;
    logic [CNT_W-1:0]          held_next;

    logic [MAX_DELIM-1:0][7:0] ext;
    logic [CNT_W-1:0]          fill;
    logic [MAX_DELIM:0]        suffix_ok;
    logic [CNT_W-1:0]          shift;
    logic                      full_match;

    // window with the new byte appended
    always_comb
    begin
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            if (i < int'(held_reg))
                ext[i] = window_reg[i];
            else if (i == int'(held_reg) && item.has_byte)
                ext[i] = item.data_byte;
            else
                ext[i] = '0;
        end
        fill = item.has_byte ? held_reg + CNT_W'(1) : held_reg;
    end

    // which suffixes of the window are a delimiter prefix
    always_comb
    begin
        for (int s = 0; s <= MAX_DELIM; s++)
        begin
            suffix_ok[s] = 1'b1;
            for (int j = 0; j < MAX_DELIM - s; j++)
            begin
                if (s + j < int'(fill) && ext[s + j] != delim[8*j +: 8])
                    suffix_ok[s] = 1'b0;
            end
        end
    end

    // smallest shift that leaves a possible match start
    always_comb
    begin
        shift = fill;
        for (int s = MAX_DELIM; s >= 0; s--)
        begin
            if (suffix_ok[s])
                shift = CNT_W'(s);
        end
        full_match = item.has_byte && (shift == '0) && (fill == eff_len);
    end

    // result list for this request
    always_comb
    begin
        res       = '0;
        res_count = '0;
        priority if (eff_len == '0)
        begin
            if (item.has_byte)
            begin
                res[0]    = '{item.data_byte, 1'b1, 1'b1, item.row_last};
                res_count = BCNT_W'(1);
            end
            else if (item.row_last)
            begin
                res[0]    = '{8'd0, 1'b0, 1'b0, 1'b1};
                res_count = BCNT_W'(1);
            end
        end
        else if (full_match)
        begin
            res[0]    = '{8'd0, 1'b0, 1'b1, 1'b0};
            res_count = BCNT_W'(1);
            if (item.row_last)
            begin
                res[1]    = '{8'd0, 1'b0, 1'b1, 1'b1};
                res_count = BCNT_W'(2);
            end
        end
        else if (item.row_last)
        begin
            if (fill == '0)
            begin
                res[0]    = '{8'd0, 1'b0, 1'b1, 1'b1};
                res_count = BCNT_W'(1);
            end
            else
            begin
                // flush the whole window, the last byte closes the row
                for (int i = 0; i < MAX_DELIM; i++)
                begin
                    res[i] = '{ext[i], 1'b1, i == int'(fill) - 1, i == int'(fill) - 1};
                end
                res_count = BCNT_W'(fill);
            end
        end
        else
        begin
            // release the bytes that can no longer start a match
            for (int i = 0; i < MAX_DELIM; i++)
            begin
                res[i] = '{ext[i], 1'b1, 1'b0, 1'b0};
            end
            res_count = item.has_byte ? BCNT_W'(shift) : '0;
        end
    end

    // next window contents
    always_comb
    begin
        window_next = window_reg;
        held_next   = held_reg;
        priority if (eff_len == '0 || item.row_last || full_match)
        begin
            held_next = '0;
        end
        else if (item.has_byte)
        begin
            held_next = fill - shift;
            for (int i = 0; i < MAX_DELIM; i++)
            begin
                window_next[i] = '0;
                for (int k = 0; k < MAX_DELIM; k++)
                begin
                    if (k == i + int'(shift))
                        window_next[i] = ext[k];
                end
            end
        end
    end

    // held count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (cfg_clear)
            held_reg <= '0;
        else if (fire)
            held_reg <= held_next;
    end

    // window bytes
    always_ff @(posedge clk)
    begin
        if (fire)
            window_reg <= window_next;
    end

    // held bytes always stay short of a full delimiter
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg == '0 || held_reg < eff_len)
        else $error("dss_match: held count reached the delimiter length");

    // a full match empties the window on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && full_match && !cfg_clear |=> held_reg == '0)
        else $error("dss_match: window not cleared after a match");

endmodule

>>> rtl/core/dss_batch.sv
// ---------------------------------------------------------------------------
// dss_batch
// Result buffer: holds the result list of one request and hands it out one
// result per cycle from its head while result_ready is high.
// ---------------------------------------------------------------------------
module dss_batch
    import dss_pkg::*;
#(
    parameter int BATCH_DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  result_t [BATCH_DEPTH-1:0]            load_res,
    input  logic [$clog2(BATCH_DEPTH + 1)-1:0]   load_count,
    input  logic                                 result_ready,
    output logic                                 result_valid,
    output result_t                              head,
    output logic                                 free
);

    localparam int BCNT_W = $clog2(BATCH_DEPTH + 1);

    result_t [BATCH_DEPTH-1:0] res_reg;
    result_t [BATCH_DEPTH-1:0] res_next;
    logic [BCNT_W-1:0]         cnt_reg;
    logic [BCNT_W-1:0]         cnt_next;
    logic                      pop;

    // handshake status
    assign pop          = (cnt_reg != '0) && result_ready;
    assign free         = (cnt_reg == '0) || (cnt_reg == BCNT_W'(1) && result_ready);
    assign result_valid = (cnt_reg != '0);
    assign head         = res_reg[0];

    // drain by shifting, then take a new list
    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            for (int i = 0; i < BATCH_DEPTH - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
            cnt_next = cnt_reg - BCNT_W'(1);
        end
        if (load && load_count != '0)
        begin
            res_next = load_res;
            cnt_next = load_count;
        end
    end

    // result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // a new list never lands on results still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        load && load_count != '0 |-> cnt_reg == '0 || (cnt_reg == BCNT_W'(1) && pop))
        else $error("dss_batch: list loaded over pending results");

    // count never exceeds the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= BCNT_W'(BATCH_DEPTH))
        else $error("dss_batch: result count out of range");

endmodule

>>> rtl/core/delimiter_string_splitter_core.sv
// ---------------------------------------------------------------------------
// delimiter_string_splitter_core
// Splits byte rows into pieces at a programmable delimiter of 0 to 8 bytes.
// ---------------------------------------------------------------------------
// Bytes enter one per request and leave as results (piece byte, piece end, both
// or a bare row end). A request passes an input register and then the parallel
// window compare, which writes its whole result list into a result buffer; the
// first result shows once the buffer has taken that list. The single result
// port sets the rate: requests with zero or one result, like plain row bytes,
// stream at one per cycle while result_ready is high, while a request with k
// results (a row-end flush of up to MAX_DELIM bytes, a match on a row end, or a
// broken partial match) holds the input while the buffer drains. Configuration
// writes clear the held bytes and are to be made only while the block is idle.
module delimiter_string_splitter_core
    import dss_pkg::*;
#(
    parameter int MAX_DELIM = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        row_last,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic        piece_end,
    output logic        row_done,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int CNT_W       = $clog2(MAX_DELIM + 1);
    localparam int BATCH_DEPTH = (MAX_DELIM < 2) ? 2 : MAX_DELIM;
    localparam int BCNT_W      = $clog2(BATCH_DEPTH + 1);

    logic [3:0]                len_reg;
    logic [63:0]               delim_reg;
    logic                      cfg_wr;
    reg_idx_t                  reg_idx;
    logic [CNT_W-1:0]          eff_len;

    logic                      in_vld_reg;
    item_t                     item_reg;
    logic                      proc_fire;
    logic                      batch_free;

    result_t [BATCH_DEPTH-1:0] match_res;
    logic [BCNT_W-1:0]         match_count;
    result_t                   head;

    // register access
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_LENGTH: prdata = 64'(len_reg);
            REG_BYTES:  prdata = delim_reg;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_RESET;
            delim_reg <= DELIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_LENGTH: len_reg   <= pwdata[3:0];
                REG_BYTES:  delim_reg <= pwdata;
                default:    len_reg   <= len_reg;
            endcase
        end
    end

    // delimiter length saturated to the window size
    assign eff_len = (len_reg > 4'(MAX_DELIM)) ? CNT_W'(MAX_DELIM) : CNT_W'(len_reg);

    // input register
    assign proc_fire  = in_vld_reg && batch_free;
    assign item_ready = !in_vld_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (item_ready)
            in_vld_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            item_reg <= '{data_byte, has_byte, row_last};
    end

    // window compare and result list
    dss_match #(
        .MAX_DELIM   (MAX_DELIM),
        .BATCH_DEPTH (BATCH_DEPTH)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_clear (cfg_wr),
        .fire      (proc_fire),
        .item      (item_reg),
        .eff_len   (eff_len),
        .delim     (delim_reg),
        .res       (match_res),
        .res_count (match_count)
    );

    // result buffer
    dss_batch #(
        .BATCH_DEPTH (BATCH_DEPTH)
    ) u_batch (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (proc_fire),
        .load_res     (match_res),
        .load_count   (match_count),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .head         (head),
        .free         (batch_free)
    );

    // result fields
    assign out_byte  = head.out_byte;
    assign out_valid = head.out_valid;
    assign piece_end = head.piece_end;
    assign row_done  = head.row_done;

endmodule
